[rtl/ghps_pkg.sv]
`timescale 1ns / 1ps

package ghps_pkg;

	// cell geometry, fixed by the three-bit position fields
	localparam int unsigned CELL_SIZE = 8;
	localparam int unsigned POS_W     = 3;
	localparam logic [POS_W-1:0] CELL_LAST = POS_W'(CELL_SIZE - 1);

	// stream widths
	localparam int unsigned PIX_W     = 32;
	localparam int unsigned TICK_W    = 32;
	localparam int unsigned PHASE_W   = 5;
	localparam int unsigned IN_BITS   = PIX_W + 2 * POS_W + 2 * TICK_W + 3 + PHASE_W;
	localparam int unsigned IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
	localparam int unsigned OUT_DATA_W = PIX_W;

	// field offsets in the input tdata, lowest first
	localparam int unsigned OFS_PIX   = 0;
	localparam int unsigned OFS_X     = OFS_PIX + PIX_W;
	localparam int unsigned OFS_Y     = OFS_X + POS_W;
	localparam int unsigned OFS_TICK  = OFS_Y + POS_W;
	localparam int unsigned OFS_HOVER = OFS_TICK + TICK_W;
	localparam int unsigned OFS_LIVE  = OFS_HOVER + 1;
	localparam int unsigned OFS_CLICK = OFS_LIVE + 1;
	localparam int unsigned OFS_LAST  = OFS_CLICK + 1;
	localparam int unsigned OFS_PHASE = OFS_LAST + TICK_W;

	// shading constants
	localparam int unsigned CLICK_WINDOW   = 24;
	localparam int unsigned HOVER_BOOST    = 18;
	localparam int unsigned PULSE_BIAS     = 4;
	localparam int unsigned SPARKLE_AMOUNT = 40;
	localparam int unsigned SPARKLE_KEEP   = 255 - SPARKLE_AMOUNT;
	localparam int unsigned SPARKLE_ADD    = 255 * SPARKLE_AMOUNT;
	localparam logic [PIX_W-1:0] WHITE_ARGB        = 32'hFFFF_FFFF;
	localparam logic [PIX_W-1:0] CLICK_BORDER_ARGB = 32'hFFFF_D166;

	// mix one channel 40/255 toward white: floor((ch*215 + 10200) / 255)
	// divide by 255 through (x + 1 + (x >> 8)) >> 8, exact for x up to 65534
	function automatic logic [7:0] sparkle_ch(input logic [7:0] ch);
		logic [16:0] x;
		logic [16:0] q;
		x = 17'(ch) * 17'(SPARKLE_KEEP) + 17'(SPARKLE_ADD);
		q = (x + 17'd1 + (x >> 8)) >> 8;
		return q[7:0];
	endfunction

	// add a signed offset to a channel and clamp to 0..255
	function automatic logic [7:0] bright_ch(input logic [7:0] ch, input logic signed [7:0] d);
		logic signed [9:0] s;
		s = $signed({2'b00, ch}) + 10'(d);
		if (s < 0) begin
			return 8'd0;
		end else if (s > 10'sd255) begin
			return 8'd255;
		end
		return s[7:0];
	endfunction

endpackage

[rtl/glyph_highlight_pixel_shader.sv]
`timescale 1ns / 1ps

// channel      dir  width  contents
// s_axis_*     in   112    one pixel request with its render context
// m_axis_*     out  32     one shaded argb pixel per request
//
// three register stages, one request per clock sustained while m_axis_tready holds
// stage 1 works out click age, phase and masks, stage 2 the pulse and the
// sparkle mix (constant divide by 255), stage 3 clamps, borders and holds the result
// arst_n clears the valid bits only, the data registers need no reset
// each stage moves on when it is empty or the stage after it moves, so
// bubbles close up under a stall and nothing is lost or repeated

module glyph_highlight_pixel_shader (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// pixel_in, pos_x, pos_y, tick_now, hover_flag, live_flag, has_clicks,
	// last click tick, phase_offset, two unused bits on top
	input  logic [ghps_pkg::IN_DATA_W-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// pixel_out
	output logic [ghps_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

	// unpacked request fields
	logic [ghps_pkg::PIX_W-1:0]   in_pix;
	logic [ghps_pkg::POS_W-1:0]   in_x;
	logic [ghps_pkg::POS_W-1:0]   in_y;
	logic [ghps_pkg::TICK_W-1:0]  in_tick;
	logic                         in_hover;
	logic                         in_live;
	logic                         in_clicks;
	logic [ghps_pkg::TICK_W-1:0]  in_last;
	logic [ghps_pkg::PHASE_W-1:0] in_phase;

	assign in_pix    = s_axis_tdata[ghps_pkg::OFS_PIX +: ghps_pkg::PIX_W];
	assign in_x      = s_axis_tdata[ghps_pkg::OFS_X +: ghps_pkg::POS_W];
	assign in_y      = s_axis_tdata[ghps_pkg::OFS_Y +: ghps_pkg::POS_W];
	assign in_tick   = s_axis_tdata[ghps_pkg::OFS_TICK +: ghps_pkg::TICK_W];
	assign in_hover  = s_axis_tdata[ghps_pkg::OFS_HOVER];
	assign in_live   = s_axis_tdata[ghps_pkg::OFS_LIVE];
	assign in_clicks = s_axis_tdata[ghps_pkg::OFS_CLICK];
	assign in_last   = s_axis_tdata[ghps_pkg::OFS_LAST +: ghps_pkg::TICK_W];
	assign in_phase  = s_axis_tdata[ghps_pkg::OFS_PHASE +: ghps_pkg::PHASE_W];

	// stage control: valid bits and per-stage advance
	logic v_s1, v_s2, v_s3;
	logic adv_s1, adv_s2, adv_s3;

	assign adv_s3 = !v_s3 || m_axis_tready;
	assign adv_s2 = !v_s2 || adv_s3;
	assign adv_s1 = !v_s1 || adv_s2;
	assign s_axis_tready = adv_s1;

	// stage 1 logic: click age, triangle phase, sparkle diagonal, border position
	logic [ghps_pkg::TICK_W-1:0]  age_c;
	logic                         recent_c;
	logic [ghps_pkg::PHASE_W-1:0] ph_c;
	logic [ghps_pkg::POS_W-1:0]   diag_c;
	logic                         edge_c;

	always_comb begin
		age_c    = in_tick - in_last;
		recent_c = in_clicks && (age_c < ghps_pkg::TICK_W'(ghps_pkg::CLICK_WINDOW));
		ph_c     = in_tick[ghps_pkg::PHASE_W-1:0] + in_phase;
		diag_c   = in_x + in_y + in_tick[ghps_pkg::POS_W-1:0];
		edge_c   = (in_x == '0) || (in_y == '0) ||
		           (in_x == ghps_pkg::CELL_LAST) || (in_y == ghps_pkg::CELL_LAST);
	end

	logic [ghps_pkg::PIX_W-1:0] pix_s1;
	logic [3:0]                 tri_s1;
	logic [4:0]                 age_s1;
	logic                       live_s1, hover_s1, recent_s1, sparkle_s1, border_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_axis_tvalid) begin
			pix_s1     <= in_pix;
			// fold the 32-step phase into a 0..15 triangle
			tri_s1     <= ph_c[4] ? ~ph_c[3:0] : ph_c[3:0];
			age_s1     <= age_c[4:0];
			live_s1    <= in_live;
			hover_s1   <= in_hover;
			recent_s1  <= recent_c;
			sparkle_s1 <= in_live && (diag_c == '0);
			border_s1  <= (in_hover || recent_c) && edge_c;
		end
	end

	// stage 2 logic: pulse offset and sparkle mix
	logic [7:0]  pulse_c;
	logic [7:0]  live_term_c;
	logic [7:0]  click_term_c;
	logic [ghps_pkg::PIX_W-1:0] mix_c;

	always_comb begin
		live_term_c  = live_s1 ? (8'(tri_s1) - 8'(ghps_pkg::PULSE_BIAS)) : 8'd0;
		click_term_c = recent_s1 ? 8'(8'd3 * (8'(ghps_pkg::CLICK_WINDOW) - 8'(age_s1))) : 8'd0;
		// range -4..101, held as two's complement
		pulse_c = live_term_c + (hover_s1 ? 8'(ghps_pkg::HOVER_BOOST) : 8'd0) + click_term_c;
		if (sparkle_s1) begin
			mix_c = {8'hFF, ghps_pkg::sparkle_ch(pix_s1[23:16]),
			         ghps_pkg::sparkle_ch(pix_s1[15:8]), ghps_pkg::sparkle_ch(pix_s1[7:0])};
		end else begin
			mix_c = pix_s1;
		end
	end

	logic [ghps_pkg::PIX_W-1:0] orig_s2;
	logic [ghps_pkg::PIX_W-1:0] mix_s2;
	logic signed [7:0]          pulse_s2;
	logic                       recent_s2, border_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			orig_s2   <= pix_s1;
			mix_s2    <= mix_c;
			pulse_s2  <= $signed(pulse_c);
			recent_s2 <= recent_s1;
			border_s2 <= border_s1;
		end
	end

	// stage 3 logic: brighten with clamp, border colour, transparent bypass
	logic [ghps_pkg::PIX_W-1:0] shade_c;

	always_comb begin
		if (orig_s2[31:24] == 8'd0) begin
			shade_c = orig_s2;
		end else if (border_s2) begin
			shade_c = recent_s2 ? ghps_pkg::CLICK_BORDER_ARGB : ghps_pkg::WHITE_ARGB;
		end else begin
			shade_c = {mix_s2[31:24], ghps_pkg::bright_ch(mix_s2[23:16], pulse_s2),
			           ghps_pkg::bright_ch(mix_s2[15:8], pulse_s2),
			           ghps_pkg::bright_ch(mix_s2[7:0], pulse_s2)};
		end
	end

	logic [ghps_pkg::PIX_W-1:0] pix_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3 && v_s2) begin
			pix_s3 <= shade_c;
		end
	end

	assign m_axis_tvalid = v_s3;
	assign m_axis_tdata  = pix_s3;

	// an empty first stage always takes a request
	assert property (@(posedge clk) disable iff (!arst_n) !v_s1 |-> s_axis_tready)
		else $error("input refused with stage one empty");

	// a full, stalled pipe refuses new requests
	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && v_s3 && !m_axis_tready) |-> !s_axis_tready)
		else $error("request taken into a full stalled pipe");

	// an accepted request lands in stage one
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> v_s1)
		else $error("accepted request lost at stage one");

	// a full stage two under output stall keeps its item
	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && v_s3 && !m_axis_tready) |=> (v_s2 && $stable(mix_s2)))
		else $error("stage two item dropped under stall");

endmodule
